// ===== rtl/rme_pkg.sv =====
// ============================================================================
// rme_pkg: shared definitions for the register machine executor
// Opcodes, word sizes and default sizing of the executor blocks.
// ============================================================================
package rme_pkg;

    localparam int RME_WORD_W      = 32;
    localparam int RME_ITER_W      = $clog2(RME_WORD_W);
    localparam int RME_REG_COUNT   = 16;
    localparam int RME_QUEUE_DEPTH = 2;
    localparam int RME_CMD_W       = 3;

    typedef enum logic [RME_CMD_W-1:0] {
        OP_NOP   = 3'd0,
        OP_COPY  = 3'd1,
        OP_LOAD  = 3'd2,
        OP_PRINT = 3'd3,
        OP_ADD   = 3'd4,
        OP_SUB   = 3'd5,
        OP_MUL   = 3'd6,
        OP_DIV   = 3'd7
    } op_t;

    localparam logic KIND_PRINT    = 1'b0;
    localparam logic KIND_DIV_ZERO = 1'b1;

endpackage

// ===== rtl/rme_front.sv =====
// ============================================================================
// rme_front: instruction intake
// Reduces register indexes modulo the file size, picks the read port A
// source, drops no-ops and packs the decoded instruction for the queue.
// ============================================================================
module rme_front
    import rme_pkg::*;
#(
    parameter int REG_COUNT = RME_REG_COUNT,
    parameter int IDX_W     = $clog2(REG_COUNT),
    parameter int INSTR_W   = RME_CMD_W + 3 * IDX_W + RME_WORD_W
)
(
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [RME_CMD_W-1:0]         cmd,
    input  logic [3:0]                   dest_reg,
    input  logic signed [RME_WORD_W-1:0] operand_a,
    input  logic [3:0]                   src_b,
    output logic                         push_valid,
    input  logic                         push_ready,
    output logic [INSTR_W-1:0]           push_data
);

    // Restoring reduction of an 8-bit index, one compare-subtract per bit.
    function automatic logic [IDX_W-1:0] reduce_idx(input logic [7:0] raw);
        logic [16:0] x;
        logic [16:0] step;
        int          k;
        x = {9'd0, raw};
        for (k = 7; k >= 0; k--) begin
            step = 17'(REG_COUNT) << k;
            if (x >= step) begin
                x = x - step;
            end
        end
        return x[IDX_W-1:0];
    endfunction

    op_t             op;
    logic [IDX_W-1:0] dst_idx;
    logic [IDX_W-1:0] sa_idx;
    logic [IDX_W-1:0] sb_idx;
    logic [IDX_W-1:0] ra_idx;

    always_comb
    begin
        op      = op_t'(cmd);
        dst_idx = reduce_idx({4'd0, dest_reg});
        sa_idx  = reduce_idx(operand_a[7:0]);
        sb_idx  = reduce_idx({4'd0, src_b});
        // print reads its register through port A
        ra_idx  = (op == OP_PRINT) ? dst_idx : sa_idx;
    end

    // no-ops are taken and discarded here
    assign in_ready   = push_ready;
    assign push_valid = in_valid && (op != OP_NOP);
    assign push_data  = {cmd, ra_idx, sb_idx, dst_idx, operand_a};

endmodule

// ===== rtl/rme_queue.sv =====
// ============================================================================
// rme_queue: decoded instruction queue
// Small FIFO between intake and execution.
// ============================================================================
module rme_queue
    import rme_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = RME_QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_mem[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            slot_mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/rme_back.sv =====
// ============================================================================
// rme_back: execution engine
// Register file, ALU ops computed in the read state, shared radix-2
// multiply/divide unit and the result output register.
// ============================================================================
module rme_back
    import rme_pkg::*;
#(
    parameter int REG_COUNT = RME_REG_COUNT,
    parameter int IDX_W     = $clog2(REG_COUNT),
    parameter int INSTR_W   = RME_CMD_W + 3 * IDX_W + RME_WORD_W
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         pop_valid,
    output logic                         pop_ready,
    input  logic [INSTR_W-1:0]           pop_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [RME_WORD_W-1:0] value,
    output logic                         kind
);

    localparam int W = RME_WORD_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_ITER  = 5'b00100,
        S_WRITE = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // unpacked queue head
    op_t              q_op;
    logic [IDX_W-1:0] q_ra;
    logic [IDX_W-1:0] q_sb;
    logic [IDX_W-1:0] q_dst;
    logic [W-1:0]     q_imm;

    assign q_op  = op_t'(pop_data[INSTR_W-1 -: RME_CMD_W]);
    assign q_ra  = pop_data[W + 3*IDX_W - 1 -: IDX_W];
    assign q_sb  = pop_data[W + 2*IDX_W - 1 -: IDX_W];
    assign q_dst = pop_data[W + IDX_W - 1 -: IDX_W];
    assign q_imm = pop_data[W-1:0];

    logic [W-1:0]         regs_mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;

    // latched instruction and operands
    op_t              op_reg;
    logic [IDX_W-1:0] dst_reg;
    logic [W-1:0]     imm_reg;
    logic [W-1:0]     rd_a_reg;
    logic [W-1:0]     rd_b_reg;
    logic             va_reg;
    logic             vb_reg;

    // iterative unit
    logic [W-1:0]          acc_reg;
    logic [W-1:0]          x_reg;
    logic [W-1:0]          y_reg;
    logic                  neg_reg;
    logic [RME_ITER_W-1:0] cnt_reg;
    logic [W-1:0]          res_reg;
    logic                  err_reg;

    logic                  out_valid_reg;
    logic [W-1:0]          value_reg;
    logic                  kind_reg;

    logic         pop;
    logic         out_load;
    logic         last_iter;
    logic [W-1:0] a_val;
    logic [W-1:0] b_val;
    logic [W-1:0] x_init;
    logic [W-1:0] y_init;
    logic         neg_init;
    logic         err_init;
    logic [W-1:0] mul_sum;
    logic [W:0]   div_trial;
    logic [W-1:0] div_diff;
    logic         div_ge;
    logic [W-1:0] wdata;

    assign pop       = (state_reg == S_IDLE) && pop_valid;
    assign pop_ready = (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);
    assign last_iter = (cnt_reg == RME_ITER_W'(W - 1));

    always_comb
    begin
        // entries never written since reset read as zero
        a_val     = va_reg ? rd_a_reg : '0;
        b_val     = vb_reg ? rd_b_reg : '0;
        x_init    = a_val;
        y_init    = b_val;
        neg_init  = 1'b0;
        err_init  = KIND_PRINT;
        if (op_reg == OP_DIV) begin
            // divide on magnitudes, sign fixed at write-back
            x_init   = a_val[W-1] ? (~a_val + 1'b1) : a_val;
            y_init   = b_val[W-1] ? (~b_val + 1'b1) : b_val;
            neg_init = a_val[W-1] ^ b_val[W-1];
            err_init = (b_val == '0) ? KIND_DIV_ZERO : KIND_PRINT;
        end
        mul_sum   = acc_reg + (y_reg[0] ? x_reg : '0);
        div_trial = {acc_reg, x_reg[W-1]};
        div_diff  = div_trial[W-1:0] - y_reg;
        div_ge    = (div_trial >= {1'b0, y_reg});
        wdata     = neg_reg ? (~res_reg + 1'b1) : res_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop_valid) begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (op_reg == OP_PRINT) begin
                    state_next = S_EMIT;
                end else if (op_reg == OP_DIV && b_val == '0) begin
                    state_next = S_EMIT;
                end else if (op_reg == OP_MUL || op_reg == OP_DIV) begin
                    state_next = S_ITER;
                end else begin
                    state_next = S_WRITE;
                end
            end
            S_ITER:
            begin
                if (last_iter) begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                state_next = S_IDLE;
            end
            S_EMIT:
            begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_WRITE) begin
                valid_reg[dst_reg] <= 1'b1;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_READ) begin
                cnt_reg <= '0;
            end else if (state_reg == S_ITER) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // register file: two registered read ports, one write port
    always_ff @(posedge clk)
    begin
        if (pop) begin
            rd_a_reg <= regs_mem[q_ra];
            rd_b_reg <= regs_mem[q_sb];
        end
        if (state_reg == S_WRITE) begin
            regs_mem[dst_reg] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            op_reg  <= q_op;
            dst_reg <= q_dst;
            imm_reg <= q_imm;
            va_reg  <= valid_reg[q_ra];
            vb_reg  <= valid_reg[q_sb];
        end

        if (state_reg == S_READ) begin
            acc_reg <= '0;
            neg_reg <= neg_init;
            err_reg <= err_init;
            x_reg   <= x_init;
            y_reg   <= y_init;
            unique case (op_reg)
                OP_COPY:  res_reg <= a_val;
                OP_LOAD:  res_reg <= imm_reg;
                OP_PRINT: res_reg <= a_val;
                OP_ADD:   res_reg <= a_val + b_val;
                OP_SUB:   res_reg <= a_val - b_val;
                OP_DIV:   res_reg <= '0;
                default:  res_reg <= '0;
            endcase
        end

        if (state_reg == S_ITER) begin
            if (op_reg == OP_MUL) begin
                acc_reg <= mul_sum;
                x_reg   <= x_reg << 1;
                y_reg   <= y_reg >> 1;
                if (last_iter) begin
                    res_reg <= mul_sum;
                end
            end else begin
                acc_reg <= div_ge ? div_diff : div_trial[W-1:0];
                x_reg   <= {x_reg[W-2:0], div_ge};
                if (last_iter) begin
                    res_reg <= {x_reg[W-2:0], div_ge};
                end
            end
        end

        if (out_load) begin
            value_reg <= res_reg;
            kind_reg  <= err_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign kind      = kind_reg;

endmodule

// ===== rtl/register_machine_executor_core.sv =====
// ============================================================================
// register_machine_executor_core: three-address register machine
// Top level: intake, instruction queue and execution engine.
// ============================================================================
// Executes one instruction per item against REG_COUNT 32-bit signed
// registers, all zero after reset. Ops: copy, load immediate, print, add,
// subtract, multiply, divide (truncating, wraps on most-negative / -1).
// Register indexes are reduced modulo REG_COUNT. Print and division by
// zero each produce one result item (kind 0 value, kind 1 error with value
// 0); a divide by zero leaves the destination unchanged; opcode 0 is a
// no-op that is taken and discarded. The intake takes items into a
// two-entry queue while the engine runs. The engine handles one
// instruction at a time: pop and register read, operate, then write back
// for copy, load, add and subtract, or emit, held by any output stall, for
// print and divide by zero. Multiply and divide iterate in the shared
// radix-2 unit, which retires one bit per cycle. The result register lets
// the next instruction start while a result waits.
// ============================================================================
module register_machine_executor_core
    import rme_pkg::*;
#(
    parameter int REG_COUNT = RME_REG_COUNT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [RME_CMD_W-1:0]         cmd,
    input  logic [3:0]                   dest_reg,
    input  logic signed [RME_WORD_W-1:0] operand_a,
    input  logic [3:0]                   src_b,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [RME_WORD_W-1:0] value,
    output logic                         kind
);

    localparam int IDX_W   = $clog2(REG_COUNT);
    // packed instruction: op, port A index, port B index, destination, immediate
    localparam int INSTR_W = RME_CMD_W + 3 * IDX_W + RME_WORD_W;

    logic               push_valid;
    logic               push_ready;
    logic [INSTR_W-1:0] push_data;
    logic               pop_valid;
    logic               pop_ready;
    logic [INSTR_W-1:0] pop_data;

    rme_front #(
        .REG_COUNT (REG_COUNT),
        .IDX_W     (IDX_W),
        .INSTR_W   (INSTR_W)
    ) u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .dest_reg   (dest_reg),
        .operand_a  (operand_a),
        .src_b      (src_b),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    rme_queue #(
        .WIDTH (INSTR_W),
        .DEPTH (RME_QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_data)
    );

    rme_back #(
        .REG_COUNT (REG_COUNT),
        .IDX_W     (IDX_W),
        .INSTR_W   (INSTR_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .kind      (kind)
    );

endmodule
